/* rtl/core/shp_pkg.sv */
// ----------------------------------------------------------------------------
// shp_pkg: shared types, constants and tables of the spiral hole position block
// Widths of the hole number, diameter, results and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package shp_pkg;

  localparam int unsigned HoleW    = 24;
  localparam int unsigned DiamW    = 16;
  localparam int unsigned PosW     = 25;
  localparam int unsigned RootW    = 20;  // floor(sqrt(N*2^16)) < 2^20
  localparam int unsigned RadW     = 31;
  localparam int unsigned AngW     = 32;
  localparam int unsigned VecW     = 33;  // signed Q30 vector with headroom
  localparam int unsigned AtanN    = 24;
  localparam int unsigned StagesDef = 16;

  localparam logic [35:0] PhaseK   = 36'd43748177637;
  localparam logic [VecW-1:0] GainInv = 33'd652032874;
  localparam logic [DiamW-1:0] DiamReset = 16'd256;

  typedef logic signed [VecW-1:0] vec_t;

  function automatic logic [AngW-1:0] atan_lookup(input int unsigned idx);
    logic [AngW-1:0] v;
    v = '0;
    unique case (idx)
      0:  v = 32'd536870912;
      1:  v = 32'd316933406;
      2:  v = 32'd167458907;
      3:  v = 32'd85004756;
      4:  v = 32'd42667331;
      5:  v = 32'd21354465;
      6:  v = 32'd10679838;
      7:  v = 32'd5340245;
      8:  v = 32'd2670163;
      9:  v = 32'd1335087;
      10: v = 32'd667544;
      11: v = 32'd333772;
      12: v = 32'd166886;
      13: v = 32'd83443;
      14: v = 32'd41722;
      15: v = 32'd20861;
      16: v = 32'd10430;
      17: v = 32'd5215;
      18: v = 32'd2608;
      19: v = 32'd1304;
      20: v = 32'd652;
      21: v = 32'd326;
      22: v = 32'd163;
      23: v = 32'd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

/* rtl/core/shp_sqrt.sv */
// ----------------------------------------------------------------------------
// shp_sqrt: pipelined integer square root
// One result bit per stage, restoring method, diameter carried alongside.
// ----------------------------------------------------------------------------
module shp_sqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  logic [shp_pkg::HoleW-1:0]  hole_i,
  input  logic [shp_pkg::DiamW-1:0]  diam_i,
  output logic                       valid_o,
  output logic [shp_pkg::RootW-1:0]  root_o,
  output logic [shp_pkg::DiamW-1:0]  diam_o
);
  import shp_pkg::*;

  localparam int unsigned RadW2 = 2 * RootW;  // radicand width

  logic [RootW:0]        vld_q;
  logic [RadW2-1:0]      rad_q  [RootW+1];
  logic [RootW+1:0]      rem_q  [RootW+1];
  logic [RootW-1:0]      rt_q   [RootW+1];
  logic [DiamW-1:0]      dia_q  [RootW+1];

  always_comb begin
    rad_q[0] = {hole_i, 16'd0};
    rem_q[0] = '0;
    rt_q[0]  = '0;
    dia_q[0] = diam_i;
  end
  assign vld_q[0] = valid_i;

  for (genvar k = 0; k < RootW; k++) begin : g_stage
    logic [RootW+1:0] rem_d, trial;
    logic [RootW-1:0] rt_d;
    logic [RootW+1:0] r_cand;
    always_comb begin
      r_cand = {rem_q[k][RootW-1:0], rad_q[k][RadW2-1 -: 2]};
      trial  = {rt_q[k], 2'b01};
      if (r_cand >= trial) begin
        rem_d = r_cand - trial;
        rt_d  = {rt_q[k][RootW-2:0], 1'b1};
      end else begin
        rem_d = r_cand;
        rt_d  = {rt_q[k][RootW-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else begin
        vld_q[k+1] <= vld_q[k];
      end
    end
    always_ff @(posedge clk_i) begin
      rad_q[k+1] <= {rad_q[k][RadW2-3:0], 2'b00};
      rem_q[k+1] <= rem_d;
      rt_q[k+1]  <= rt_d;
      dia_q[k+1] <= dia_q[k];
    end
  end

  assign valid_o = vld_q[RootW];
  assign root_o  = rt_q[RootW];
  assign diam_o  = dia_q[RootW];

endmodule

/* rtl/core/shp_prep.sv */
// ----------------------------------------------------------------------------
// shp_prep: radius and phase from the root
// Radius d*s/40 rounded via reciprocal multiply, phase s*K rounded to turns,
// then quadrant split; three register stages.
// ----------------------------------------------------------------------------
module shp_prep (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  logic [shp_pkg::RootW-1:0] root_i,
  input  logic [shp_pkg::DiamW-1:0] diam_i,
  output logic                      valid_o,
  output logic [shp_pkg::RadW-1:0]  radius_o,
  output logic [1:0]                quad_o,
  output logic signed [shp_pkg::AngW-1:0] resid_o
);
  import shp_pkg::*;

  localparam int unsigned ProdW = DiamW + RootW;  // 36
  // floor(v/40) for v < 2^37 via v*ceil(2^43/40) >> 43, exact over that range
  localparam logic [37:0] Recip40 = 38'd219902325556;

  logic [2:0]            vld_q;
  logic [ProdW:0]        num_q;
  logic [RootW+35:0]     ph_q;
  logic [ProdW+19:0]     plo_q, phi_q;
  logic [RadW-1:0]       rad2_q;
  logic [AngW-1:0]       p_q;
  logic [ProdW+38:0]     qt_w;
  logic [ProdW:0]        qcand;
  logic [AngW-1:0]       pd;
  logic [1:0]            qd;
  logic [AngW-1:0]       rd;

  assign pd = AngW'((ph_q + (RootW+36)'(33'd32768)) >> 16);
  // reciprocal product rebuilt from its two registered halves
  assign qt_w = {phi_q, 19'd0} + (ProdW+39)'(plo_q);
  assign qcand = (ProdW+1)'(qt_w >> 43);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    // stage 1: products
    num_q  <= (ProdW+1)'(diam_i * root_i) + (ProdW+1)'(20);
    ph_q   <= root_i * PhaseK;
    // stage 2: reciprocal partial products and phase
    plo_q  <= num_q * Recip40[18:0];
    phi_q  <= num_q * Recip40[37:19];
    p_q    <= pd;
    // stage 3: quotient and quadrant split
    rad2_q <= RadW'(qcand);
    quad_o <= qd;
    resid_o <= rd;
  end

  always_comb begin
    qd = 2'((p_q + 32'h2000_0000) >> 30);
    rd = p_q - {qd, 30'd0};
  end

  assign valid_o  = vld_q[2];
  assign radius_o = rad2_q;

endmodule

/* rtl/core/shp_cordic.sv */
// ----------------------------------------------------------------------------
// shp_cordic: rotation-mode CORDIC, one stage per register
// Rotates the pre-scaled unit vector by the residual, then by the quadrant.
// ----------------------------------------------------------------------------
module shp_cordic #(
  parameter int unsigned Stages = shp_pkg::StagesDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             valid_i,
  input  logic [shp_pkg::RadW-1:0]         radius_i,
  input  logic [1:0]                       quad_i,
  input  logic signed [shp_pkg::AngW-1:0]  resid_i,
  output logic                             valid_o,
  output logic [shp_pkg::RadW-1:0]         radius_o,
  output shp_pkg::vec_t                    cos_o,
  output shp_pkg::vec_t                    sin_o
);
  import shp_pkg::*;

  localparam int unsigned Run = (Stages < AtanN) ? Stages : AtanN;

  logic [Run:0]          vld_q;
  vec_t                  x_q [Run+1];
  vec_t                  y_q [Run+1];
  logic signed [AngW+1:0] z_q [Run+1];
  logic [RadW-1:0]       r_q [Run+1];
  logic [1:0]            qu_q [Run+1];

  assign vld_q[0] = valid_i;
  always_comb begin
    x_q[0]  = GainInv;
    y_q[0]  = '0;
    z_q[0]  = (AngW+2)'(resid_i);
    r_q[0]  = radius_i;
    qu_q[0] = quad_i;
  end

  for (genvar i = 0; i < Run; i++) begin : g_rot
    localparam logic signed [AngW+1:0] At = (AngW+2)'(atan_lookup(i));
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i+1] <= 1'b0;
      end else begin
        vld_q[i+1] <= vld_q[i];
      end
    end
    always_ff @(posedge clk_i) begin
      if (!z_q[i][AngW+1]) begin
        x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
        y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
        z_q[i+1] <= z_q[i] - At;
      end else begin
        x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
        y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
        z_q[i+1] <= z_q[i] + At;
      end
      r_q[i+1]  <= r_q[i];
      qu_q[i+1] <= qu_q[i];
    end
  end

  logic vld_out_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_out_q <= 1'b0;
    end else begin
      vld_out_q <= vld_q[Run];
    end
  end

  always_ff @(posedge clk_i) begin
    radius_o <= r_q[Run];
    unique case (qu_q[Run])
      2'd0: begin cos_o <= x_q[Run];  sin_o <= y_q[Run];  end
      2'd1: begin cos_o <= -y_q[Run]; sin_o <= x_q[Run];  end
      2'd2: begin cos_o <= -x_q[Run]; sin_o <= -y_q[Run]; end
      default: begin cos_o <= y_q[Run]; sin_o <= -x_q[Run]; end
    endcase
  end

  assign valid_o = vld_out_q;

endmodule

/* rtl/core/shp_scale.sv */
// ----------------------------------------------------------------------------
// shp_scale: radius times cosine and sine, rounded half away from zero to Q8
// Magnitude split into 16-bit partial products over two register stages.
// ----------------------------------------------------------------------------
module shp_scale (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  logic [shp_pkg::RadW-1:0]  radius_i,
  input  shp_pkg::vec_t             cos_i,
  input  shp_pkg::vec_t             sin_i,
  output logic                      valid_o,
  output logic [shp_pkg::PosW-1:0]  x_o,
  output logic [shp_pkg::PosW-1:0]  y_o
);
  import shp_pkg::*;

  localparam int unsigned MagW = VecW - 1;
  localparam int unsigned HiW  = MagW - 16;
  localparam int unsigned PW   = RadW + MagW;

  logic [1:0]            vld_q;
  logic [MagW-1:0]       mc, ms;
  logic                  nc_q, ns_q;
  logic [RadW+15:0]      cl_q, sl_q;
  logic [RadW+HiW-1:0]   ch_q, sh_q;
  logic [PW-1:0]         cp, sp;
  logic [PosW-1:0]       cq, sq;

  assign mc = MagW'(cos_i[VecW-1] ? -cos_i : cos_i);
  assign ms = MagW'(sin_i[VecW-1] ? -sin_i : sin_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[0], valid_i};
    end
  end

  assign cp = PW'({ch_q, 16'd0}) + PW'(cl_q) + PW'(64'h20_0000_0000);
  assign sp = PW'({sh_q, 16'd0}) + PW'(sl_q) + PW'(64'h20_0000_0000);
  assign cq = PosW'(cp >> 38);
  assign sq = PosW'(sp >> 38);

  always_ff @(posedge clk_i) begin
    cl_q  <= radius_i * mc[15:0];
    ch_q  <= radius_i * mc[MagW-1:16];
    sl_q  <= radius_i * ms[15:0];
    sh_q  <= radius_i * ms[MagW-1:16];
    nc_q  <= cos_i[VecW-1];
    ns_q  <= sin_i[VecW-1];
    x_o   <= nc_q ? -cq : cq;
    y_o   <= ns_q ? -sq : sq;
  end

  assign valid_o = vld_q[1];

endmodule

/* rtl/core/spiral_hole_position.sv */
// ----------------------------------------------------------------------------
// spiral_hole_position: hole coordinates on a square-root Archimedean spiral
// Pipelined root, radius/phase, CORDIC and output scaling.
// ----------------------------------------------------------------------------
// channel    ports                              timing
// config     hole_diameter_we_i, _i             write at any edge with we high
// input      start_i, busy_o, hole_number_i     beat when start and not busy
// result     done_o, x_position_o, y_position_o one cycle, strobe done_o
//
// one item per cycle; the path runs through the root, prep, CORDIC and output scaling stages.
// busy_o is always low: every stage advances each cycle.
// reset clears valid bits and loads the diameter with 1.0.
// the receiver cannot stall, so no back-pressure path exists.
module spiral_hole_position #(
  parameter int unsigned CORDIC_STAGES = shp_pkg::StagesDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        hole_diameter_we_i,
  input  logic [shp_pkg::DiamW-1:0]   hole_diameter_i,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [shp_pkg::HoleW-1:0]   hole_number_i,
  output logic                        done_o,
  output logic signed [shp_pkg::PosW-1:0] x_position_o,
  output logic signed [shp_pkg::PosW-1:0] y_position_o
);
  import shp_pkg::*;

  logic [DiamW-1:0] diam_q;
  logic             v1, v2, v3;
  logic [RootW-1:0] root;
  logic [DiamW-1:0] dia1;
  logic [RadW-1:0]  rad2, rad3;
  logic [1:0]       quad;
  logic signed [AngW-1:0] resid;
  vec_t             cv, sv;
  logic [PosW-1:0]  xo, yo;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      diam_q <= DiamReset;
    end else if (hole_diameter_we_i) begin
      diam_q <= hole_diameter_i;
    end
  end

  assign busy_o = 1'b0;

  shp_sqrt u_sqrt (
    .clk_i, .rst_ni, .valid_i(start_i), .hole_i(hole_number_i), .diam_i(diam_q),
    .valid_o(v1), .root_o(root), .diam_o(dia1)
  );

  shp_prep u_prep (
    .clk_i, .rst_ni, .valid_i(v1), .root_i(root), .diam_i(dia1),
    .valid_o(v2), .radius_o(rad2), .quad_o(quad), .resid_o(resid)
  );

  shp_cordic #(.Stages(CORDIC_STAGES)) u_cordic (
    .clk_i, .rst_ni, .valid_i(v2), .radius_i(rad2), .quad_i(quad),
    .resid_i(resid), .valid_o(v3), .radius_o(rad3), .cos_o(cv), .sin_o(sv)
  );

  shp_scale u_scale (
    .clk_i, .rst_ni, .valid_i(v3), .radius_i(rad3), .cos_i(cv), .sin_i(sv),
    .valid_o(done_o), .x_o(xo), .y_o(yo)
  );

  assign x_position_o = xo;
  assign y_position_o = yo;

  // a result leaves the scaler through its product and output registers after the CORDIC hands it over
  a_busy_low: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy_o)
    else $error("busy raised");
  a_done_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(v3, 2)) else $error("result without item");

endmodule
